// ----- hw/rtl/bmot_pkg.sv -----
// Shared types, constants and the command decoder for the bracket matching translator.
package bmot_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned NEST_DEPTH = 256;

  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned TGT_W   = 12;
  localparam int unsigned DEPTH_W = $clog2(NEST_DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_PATCH   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_UNMATCHED_CLOSE = 2'd1,
    ST_UNMATCHED_OPEN  = 2'd2,
    ST_FULL            = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_INC   = 3'd0,
    OP_DEC   = 3'd1,
    OP_RIGHT = 3'd2,
    OP_LEFT  = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } dec_t;

  typedef struct packed {
    logic              push;
    logic              pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        op;
    logic [TGT_W-1:0]  tgt;
    logic [1:0]        status;
    logic              last;
  } result_t;

  function automatic dec_t decode_cmd(logic [7:0] ch);
    dec_t d;
    d.valid = 1'b1;
    d.op    = OP_INC;
    case (ch)
      CH_PLUS:  d.op = OP_INC;
      CH_MINUS: d.op = OP_DEC;
      CH_RIGHT: d.op = OP_RIGHT;
      CH_LEFT:  d.op = OP_LEFT;
      CH_DOT:   d.op = OP_OUT;
      CH_COMMA: d.op = OP_IN;
      CH_OPEN:  d.op = OP_OPEN;
      CH_CLOSE: d.op = OP_CLOSE;
      default:  d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/bmot_cell.sv -----
// One cell of the shifting bracket stack: takes its left neighbor on push, its right on pop.
module bmot_cell
  import bmot_pkg::*;
(
  input  logic             clk_i,
  input  stk_ctrl_t        ctrl_i,
  input  logic [TGT_W-1:0] left_i,
  input  logic [TGT_W-1:0] right_i,
  output logic [TGT_W-1:0] data_o
);

  logic [TGT_W-1:0] data_q;
  logic [TGT_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = left_i;
    end else if (ctrl_i.pop) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/bracket_matching_opcode_translator_top.sv -----
// Top level of the bracket matching translator: decoder, cell stack and result buffer.
// Each accepted source byte is decoded in the cycle it is accepted, and its results land in a
// two-entry output buffer. Bytes that give no result or one result are taken at one per cycle
// while the output side keeps taking items. A close bracket that finds its open bracket gives
// two results, and the next item is not taken until the close write has left the buffer. The
// open-bracket addresses live in a row of 256 cells that all shift one place on a push or a
// pop, so the top of the stack is always in the first cell and no clearing is needed after
// reset. The end marker gives a summary item and returns the address counter, nesting depth
// and error status to their reset values.
module bracket_matching_opcode_translator_top
  import bmot_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_source_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [ADDR_W-1:0] write_address_o,
  output logic [2:0]        opcode_o,
  output logic [TGT_W-1:0]  jump_target_o,
  output logic [1:0]        status_o,
  output logic              last_result_o
);

  logic [ADDR_W-1:0]  pc_q, pc_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [1:0]         err_q, err_d;
  logic [1:0]         count_q;
  result_t            slot_q [2];
  result_t            res0, res1;
  logic [1:0]         nres;
  logic               accept;
  logic               pop_out;
  logic               push, pop;
  dec_t               dec;
  stk_ctrl_t          stk_ctrl;
  logic [TGT_W-1:0]   cell_data [NEST_DEPTH];
  logic [TGT_W-1:0]   top_entry;

  assign out_valid_o = (count_q != 2'd0);
  assign pop_out     = out_valid_o && out_ready_i;
  assign in_ready_o  = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign dec         = decode_cmd(char_code_i);
  assign top_entry   = cell_data[0];

  always_comb begin
    pc_d    = pc_q;
    depth_d = depth_q;
    err_d   = err_q;
    push    = 1'b0;
    pop     = 1'b0;
    nres    = 2'd0;
    res0    = '0;
    res1    = '0;
    if (end_of_source_i) begin
      res0.kind = KIND_SUMMARY;
      res0.addr = pc_q;
      res0.last = 1'b1;
      if (err_q != ST_OK) begin
        res0.status = err_q;
      end else if (depth_q != '0) begin
        res0.status = ST_UNMATCHED_OPEN;
      end else begin
        res0.status = ST_OK;
      end
      nres    = 2'd1;
      pc_d    = '0;
      depth_d = '0;
      err_d   = ST_OK;
    end else if (dec.valid) begin
      if (pc_q >= ADDR_W'(PROG_DEPTH)) begin
        if (err_q == ST_OK) begin
          err_d = ST_FULL;
        end
      end else begin
        pc_d      = pc_q + ADDR_W'(1);
        res0.kind = KIND_WRITE;
        res0.addr = pc_q;
        res0.op   = dec.op;
        res0.last = 1'b1;
        nres      = 2'd1;
        case (dec.op)
          OP_OPEN: begin
            if (depth_q < DEPTH_W'(NEST_DEPTH)) begin
              push    = 1'b1;
              depth_d = depth_q + DEPTH_W'(1);
            end else if (err_q == ST_OK) begin
              err_d = ST_FULL;
            end
          end
          OP_CLOSE: begin
            if (depth_q == '0) begin
              if (err_q == ST_OK) begin
                err_d = ST_UNMATCHED_CLOSE;
              end
            end else begin
              pop       = 1'b1;
              depth_d   = depth_q - DEPTH_W'(1);
              res0.tgt  = top_entry;
              res0.last = 1'b0;
              res1.kind = KIND_PATCH;
              res1.addr = ADDR_W'(top_entry);
              res1.op   = OP_OPEN;
              res1.tgt  = pc_q[TGT_W-1:0];
              res1.last = 1'b1;
              nres      = 2'd2;
            end
          end
          default: begin
            res0.op = dec.op;
          end
        endcase
      end
      res0.status = err_d;
      res1.status = err_d;
    end
  end

  assign stk_ctrl.push = accept && push;
  assign stk_ctrl.pop  = accept && pop;

  for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
    logic [TGT_W-1:0] left_in;
    logic [TGT_W-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = pc_q[TGT_W-1:0];
    end else begin : g_body
      assign left_in = cell_data[i-1];
    end
    if (i == NEST_DEPTH - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_inner
      assign right_in = cell_data[i+1];
    end
    bmot_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (stk_ctrl),
      .left_i  (left_in),
      .right_i (right_in),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      depth_q <= '0;
      err_q   <= ST_OK;
      count_q <= 2'd0;
    end else begin
      if (accept) begin
        pc_q    <= pc_d;
        depth_q <= depth_d;
        err_q   <= err_d;
      end
      if (accept && (nres != 2'd0)) begin
        count_q <= nres;
      end else if (pop_out) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (nres != 2'd0)) begin
      slot_q[0] <= res0;
      slot_q[1] <= res1;
    end else if (pop_out) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assign result_kind_o   = slot_q[0].kind;
  assign write_address_o = slot_q[0].addr;
  assign opcode_o        = slot_q[0].op;
  assign jump_target_o   = slot_q[0].tgt;
  assign status_o        = slot_q[0].status;
  assign last_result_o   = slot_q[0].last;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(NEST_DEPTH))
    else $error("Bracket stack depth exceeds its capacity.");

  a_two_held_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> (slot_q[0].kind == KIND_WRITE) && (slot_q[0].op == OP_CLOSE) &&
                        !slot_q[0].last && (slot_q[1].kind == KIND_PATCH) && slot_q[1].last)
    else $error("Two buffered results are not a close write followed by its patch.");

  a_patch_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (slot_q[0].kind == KIND_PATCH) |-> slot_q[0].last)
    else $error("A patch item is not the last result of its source byte.");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_source_i |=> (pc_q == '0) && (depth_q == '0) && (err_q == ST_OK))
    else $error("State is not cleared after the end marker.");

  a_matched_close_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !end_of_source_i && dec.valid && (dec.op == OP_CLOSE) &&
    (pc_q < ADDR_W'(PROG_DEPTH)) && (depth_q != '0)
    |=> (count_q == 2'd2) && (depth_q == $past(depth_q) - DEPTH_W'(1)))
    else $error("A matched close bracket did not pop the stack and queue two results.");

endmodule
